[design/assert_macros.svh]
// Assertion macros shared by the tracker RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dsft_pkg.sv]
// Package for the damped spring follow tracker: widths, register defaults,
// operation codes, controller/datapath command types and fixed-point helpers.
package dsft_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TIME_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int EXT_W     = DATA_W + 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int HEAD_W    = 18;
    localparam int DT_W      = 16;
    localparam int DIST_W    = 31;
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] t_fx;
    typedef logic signed [EXT_W-1:0]  t_ext;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic [AXIS_W-1:0]        t_axis;

    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_LAST = t_axis'(AXES - 1);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HDIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VDIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = 3'd4;

    // Register defaults: 6.0, 4.0, 3.0, 64.0, 16.0 in Q16.16
    localparam logic [DIST_W-1:0] HDIST_RST = 31'd393216;
    localparam t_fx               VDIST_RST = 32'sd262144;
    localparam t_fx               LOOK_RST  = 32'sd196608;
    localparam logic [DIST_W-1:0] STIFF_RST = 31'd4194304;
    localparam logic [DIST_W-1:0] DAMP_RST  = 31'd1048576;

    localparam t_fx FX_MAX = 32'sh7FFF_FFFF;
    localparam t_fx FX_MIN = 32'sh8000_0000;

    // Datapath operations, one per product or adjustment
    typedef logic [2:0] t_op;
    localparam t_op OP_BACK   = 3'd0;  // ideal = object - heading*hdist
    localparam t_op OP_AIM    = 3'd1;  // aim = object + heading*look
    localparam t_op OP_LIFT   = 3'd2;  // ideal += vdist (y only)
    localparam t_op OP_DIFF   = 3'd3;  // diff = pos - ideal, or snap
    localparam t_op OP_SPRING = 3'd4;  // spring = diff*k
    localparam t_op OP_DAMP   = 3'd5;  // accel = -spring - vel*damp
    localparam t_op OP_VEL    = 3'd6;  // vel += accel*dt
    localparam t_op OP_POS    = 3'd7;  // pos += vel*dt

    typedef struct packed {
        logic  load_in;
        logic  mul_en;
        logic  acc_en;
        t_op   op;
        t_axis axis;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic snap;
    } t_stat;

    function automatic logic op_has_mul(input t_op op);
        return !(op == OP_LIFT || op == OP_DIFF);
    endfunction

    function automatic t_ext ext34(input t_fx v);
        return {{2{v[DATA_W-1]}}, v};
    endfunction

    function automatic t_fx sat34(input t_ext v);
        if (v[EXT_W-1:DATA_W-1] == '0 || v[EXT_W-1:DATA_W-1] == '1) begin
            return v[DATA_W-1:0];
        end
        return v[EXT_W-1] ? FX_MIN : FX_MAX;
    endfunction

    // Round to nearest (ties up), floor shift, saturate to 32 bits
    function automatic t_fx round_sat(input t_prod p, input logic time_scale);
        logic signed [PROD_W:0] sum;
        logic signed [PROD_W:0] sh;
        if (time_scale) begin
            sum = $signed({p[PROD_W-1], p}) + ((PROD_W+1)'(1) <<< (TIME_BITS - 1));
            sh  = sum >>> TIME_BITS;
        end else begin
            sum = $signed({p[PROD_W-1], p}) + ((PROD_W+1)'(1) <<< (FRAC_BITS - 1));
            sh  = sum >>> FRAC_BITS;
        end
        if (sh[PROD_W:DATA_W-1] == '0 || sh[PROD_W:DATA_W-1] == '1) begin
            return sh[DATA_W-1:0];
        end
        return sh[PROD_W] ? FX_MIN : FX_MAX;
    endfunction

endpackage

[design/damped_spring_follow_tracker_top.sv]
// Top level of the damped spring follow tracker: sequencer plus datapath.
// Depends on dsft_pkg, dsft_ctrl, dsft_dp and assert_macros.svh.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------
//   input    | i_in_valid / o_in_stall    | i_mode, i_object_*, i_heading_*, i_time_step
//   output   | o_out_valid / i_out_stall  | o_camera_*, o_aim_*
//   config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A beat is taken only while the block is idle, so the next beat waits until
// the last one is finished. The single shared 32x32 multiplier serves every
// product, each one held in the product register and then rounded, added and
// saturated (six products per axis on update, two on snap).
// Synchronous active-low reset restores the register defaults and zeros the
// camera position and velocity.
// A finished result sits in the output register while the next beat is taken
// and worked on; the block holds in its final step only if that register is
// still full and stalled.
`include "assert_macros.svh"

module damped_spring_follow_tracker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_mode,
    input  logic signed [dsft_pkg::DATA_W-1:0] i_object_x,
    input  logic signed [dsft_pkg::DATA_W-1:0] i_object_y,
    input  logic signed [dsft_pkg::DATA_W-1:0] i_object_z,
    input  logic signed [dsft_pkg::HEAD_W-1:0] i_heading_x,
    input  logic signed [dsft_pkg::HEAD_W-1:0] i_heading_y,
    input  logic signed [dsft_pkg::HEAD_W-1:0] i_heading_z,
    input  logic [dsft_pkg::DT_W-1:0]          i_time_step,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [dsft_pkg::DATA_W-1:0] o_camera_x,
    output logic signed [dsft_pkg::DATA_W-1:0] o_camera_y,
    output logic signed [dsft_pkg::DATA_W-1:0] o_camera_z,
    output logic signed [dsft_pkg::DATA_W-1:0] o_aim_x,
    output logic signed [dsft_pkg::DATA_W-1:0] o_aim_y,
    output logic signed [dsft_pkg::DATA_W-1:0] o_aim_z,
    // configuration port
    input  logic                               i_cfg_we,
    input  logic [dsft_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dsft_pkg::DATA_W-1:0]        i_cfg_data
);
    import dsft_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: owns the handshakes and the operation order
    dsft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: registers, shared multiplier, saturating adders
    dsft_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_object_x  (i_object_x),
        .i_object_y  (i_object_y),
        .i_object_z  (i_object_z),
        .i_heading_x (i_heading_x),
        .i_heading_y (i_heading_y),
        .i_heading_z (i_heading_z),
        .i_time_step (i_time_step),
        .o_camera_x  (o_camera_x),
        .o_camera_y  (o_camera_y),
        .o_camera_z  (o_camera_z),
        .o_aim_x     (o_aim_x),
        .o_aim_y     (o_aim_y),
        .o_aim_z     (o_aim_z)
    );

    // An accepted beat keeps the block busy on the following cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken but block not busy")

    // Never overwrite a result that is still waiting and stalled
    `ASSERT_SAME(a_no_result_overwrite, i_clk, i_rst_n, cmd.load_out, !o_out_valid || !i_out_stall, "pending result overwritten")

    // Rounding of a product always follows its multiply cycle
    `ASSERT_SAME(a_mul_before_acc, i_clk, i_rst_n, cmd.acc_en && op_has_mul(cmd.op), $past(cmd.mul_en), "product used without multiply")

endmodule

[design/dsft_ctrl.sv]
// Sequencer for the tracker: walks axes and operations, drives the datapath.
// Depends on dsft_pkg for operation codes and the command/status structs.
module dsft_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  dsft_pkg::t_stat i_stat,
    output dsft_pkg::t_cmd  o_cmd
);
    import dsft_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ACC  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    t_op        r_op, n_op;
    t_axis      r_axis, n_axis;
    logic       r_out_valid, n_out_valid;

    t_op  nxt_op;
    logic end_axis;
    logic in_acc;
    logic load_out;

    assign in_acc   = (r_state == S_IDLE) && i_in_valid;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Operation order within one axis
    always_comb begin
        nxt_op   = r_op;
        end_axis = 1'b0;
        unique case (r_op)
            OP_BACK:   nxt_op = OP_AIM;
            OP_AIM:    nxt_op = (r_axis == AXIS_Y) ? OP_LIFT : OP_DIFF;
            OP_LIFT:   nxt_op = OP_DIFF;
            OP_DIFF: begin
                if (i_stat.snap) begin
                    end_axis = 1'b1;
                end else begin
                    nxt_op = OP_SPRING;
                end
            end
            OP_SPRING: nxt_op = OP_DAMP;
            OP_DAMP:   nxt_op = OP_VEL;
            OP_VEL:    nxt_op = OP_POS;
            OP_POS:    end_axis = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_axis  = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_MUL;
                    n_op    = OP_BACK;
                    n_axis  = '0;
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (end_axis) begin
                    if (r_axis == AXIS_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_axis  = r_axis + t_axis'(1);
                        n_op    = OP_BACK;
                        n_state = S_MUL;
                    end
                end else begin
                    n_op    = nxt_op;
                    n_state = op_has_mul(nxt_op) ? S_MUL : S_ACC;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_BACK;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load_in  = in_acc;
    assign o_cmd.mul_en   = (r_state == S_MUL);
    assign o_cmd.acc_en   = (r_state == S_ACC);
    assign o_cmd.op       = r_op;
    assign o_cmd.axis     = r_axis;
    assign o_cmd.load_out = load_out;

endmodule

[design/dsft_dp.sv]
// Datapath for the tracker: config registers, item registers, camera state,
// one shared 32x32 multiplier with a product register, and the result stage.
// Depends on dsft_pkg for types, register defaults and rounding helpers.
module dsft_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dsft_pkg::t_cmd                     i_cmd,
    output dsft_pkg::t_stat                    o_stat,
    input  logic                               i_cfg_we,
    input  logic [dsft_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dsft_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                               i_mode,
    input  logic signed [dsft_pkg::DATA_W-1:0] i_object_x,
    input  logic signed [dsft_pkg::DATA_W-1:0] i_object_y,
    input  logic signed [dsft_pkg::DATA_W-1:0] i_object_z,
    input  logic signed [dsft_pkg::HEAD_W-1:0] i_heading_x,
    input  logic signed [dsft_pkg::HEAD_W-1:0] i_heading_y,
    input  logic signed [dsft_pkg::HEAD_W-1:0] i_heading_z,
    input  logic [dsft_pkg::DT_W-1:0]          i_time_step,
    output logic signed [dsft_pkg::DATA_W-1:0] o_camera_x,
    output logic signed [dsft_pkg::DATA_W-1:0] o_camera_y,
    output logic signed [dsft_pkg::DATA_W-1:0] o_camera_z,
    output logic signed [dsft_pkg::DATA_W-1:0] o_aim_x,
    output logic signed [dsft_pkg::DATA_W-1:0] o_aim_y,
    output logic signed [dsft_pkg::DATA_W-1:0] o_aim_z
);
    import dsft_pkg::*;

    logic [DIST_W-1:0] r_hdist, r_stiff, r_damp;
    t_fx               r_vdist, r_look;

    logic                     r_mode;
    t_fx                      r_obj  [AXES];
    logic signed [HEAD_W-1:0] r_head [AXES];
    logic [DT_W-1:0]          r_dt;

    t_fx r_pos [AXES];
    t_fx r_vel [AXES];

    t_prod r_prod;
    t_fx   r_ideal, r_diff, r_spring, r_accel;
    t_fx   r_aim     [AXES];
    t_fx   r_cam_out [AXES];
    t_fx   r_aim_out [AXES];

    t_fx   mul_a, mul_b;
    t_prod n_prod;
    t_fx   rnd_f, rnd_t;
    t_fx   n_acc;
    t_fx   obj, pos, vel;

    assign obj = r_obj[i_cmd.axis];
    assign pos = r_pos[i_cmd.axis];
    assign vel = r_vel[i_cmd.axis];

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op) inside
            OP_BACK: begin
                mul_a = t_fx'(r_head[i_cmd.axis]);
                mul_b = $signed({1'b0, r_hdist});
            end
            OP_AIM: begin
                mul_a = t_fx'(r_head[i_cmd.axis]);
                mul_b = r_look;
            end
            OP_LIFT, OP_DIFF: begin
                mul_a = '0;
                mul_b = '0;
            end
            OP_SPRING: begin
                mul_a = r_diff;
                mul_b = $signed({1'b0, r_stiff});
            end
            OP_DAMP: begin
                mul_a = vel;
                mul_b = $signed({1'b0, r_damp});
            end
            OP_VEL: begin
                mul_a = r_accel;
                mul_b = $signed({{(DATA_W-DT_W){1'b0}}, r_dt});
            end
            OP_POS: begin
                mul_a = vel;
                mul_b = $signed({{(DATA_W-DT_W){1'b0}}, r_dt});
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;
    assign rnd_f  = round_sat(r_prod, 1'b0);
    assign rnd_t  = round_sat(r_prod, 1'b1);

    // Post-product add and saturate
    always_comb begin
        n_acc = '0;
        unique case (i_cmd.op)
            OP_BACK:   n_acc = sat34(ext34(obj) - ext34(rnd_f));
            OP_AIM:    n_acc = sat34(ext34(obj) + ext34(rnd_f));
            OP_LIFT:   n_acc = sat34(ext34(r_ideal) + ext34(r_vdist));
            OP_DIFF:   n_acc = sat34(ext34(pos) - ext34(r_ideal));
            OP_SPRING: n_acc = rnd_f;
            OP_DAMP:   n_acc = sat34(-ext34(r_spring) - ext34(rnd_f));
            OP_VEL:    n_acc = sat34(ext34(vel) + ext34(rnd_t));
            OP_POS:    n_acc = sat34(ext34(pos) + ext34(rnd_t));
        endcase
    end

    // Configuration registers and camera state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdist <= HDIST_RST;
            r_vdist <= VDIST_RST;
            r_look  <= LOOK_RST;
            r_stiff <= STIFF_RST;
            r_damp  <= DAMP_RST;
            for (int i = 0; i < AXES; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HDIST: r_hdist <= i_cfg_data[DIST_W-1:0];
                    CFG_VDIST: r_vdist <= i_cfg_data;
                    CFG_LOOK:  r_look  <= i_cfg_data;
                    CFG_STIFF: r_stiff <= i_cfg_data[DIST_W-1:0];
                    CFG_DAMP:  r_damp  <= i_cfg_data[DIST_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.acc_en) begin
                case (i_cmd.op)
                    OP_DIFF: begin
                        if (r_mode) begin
                            r_pos[i_cmd.axis] <= r_ideal;
                            r_vel[i_cmd.axis] <= '0;
                        end
                    end
                    OP_VEL:  r_vel[i_cmd.axis] <= n_acc;
                    OP_POS:  r_pos[i_cmd.axis] <= n_acc;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Item capture, product register, scratch and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode    <= i_mode;
            r_obj[0]  <= i_object_x;
            r_obj[1]  <= i_object_y;
            r_obj[2]  <= i_object_z;
            r_head[0] <= i_heading_x;
            r_head[1] <= i_heading_y;
            r_head[2] <= i_heading_z;
            r_dt      <= i_time_step;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.acc_en) begin
            case (i_cmd.op) inside
                OP_BACK, OP_LIFT: r_ideal <= n_acc;
                OP_AIM:           r_aim[i_cmd.axis] <= n_acc;
                OP_DIFF:          r_diff <= n_acc;
                OP_SPRING:        r_spring <= n_acc;
                OP_DAMP:          r_accel <= n_acc;
                default: begin
                end
            endcase
        end
        if (i_cmd.load_out) begin
            for (int i = 0; i < AXES; i++) begin
                r_cam_out[i] <= r_pos[i];
                r_aim_out[i] <= r_aim[i];
            end
        end
    end

    assign o_stat.snap = r_mode;

    assign o_camera_x = r_cam_out[0];
    assign o_camera_y = r_cam_out[1];
    assign o_camera_z = r_cam_out[2];
    assign o_aim_x    = r_aim_out[0];
    assign o_aim_y    = r_aim_out[1];
    assign o_aim_z    = r_aim_out[2];

endmodule

[tb/sv/damped_spring_follow_tracker_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for damped_spring_follow_tracker_top: directed and random object beats
// checked against an in-bench camera spring predictor. Depends on dsft_pkg and the tracker RTL.
module damped_spring_follow_tracker_top_tb;
    import dsft_pkg::*;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_SNAP   = 1'b1;

    // Receiver stall styles
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_COMB   = 2;

    localparam int LONG_HOLD   = 600;      // cycles of receiver hold-off under pressure
    localparam int IDLE_TAIL   = 60;       // idle tail after settling, longer than an update beat
    localparam int CYCLE_LIMIT = 1000000;

    // Common register values in Q16.16
    localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] ALL_ZERO = 32'h0000_0000;

    typedef struct packed {
        logic                     mode;
        t_fx                      obj_x;
        t_fx                      obj_y;
        t_fx                      obj_z;
        logic signed [HEAD_W-1:0] hd_x;
        logic signed [HEAD_W-1:0] hd_y;
        logic signed [HEAD_W-1:0] hd_z;
        logic [DT_W-1:0]          dt;
    } object_beat_t;

    typedef struct packed {
        t_fx cam_x;
        t_fx cam_y;
        t_fx cam_z;
        t_fx aim_x;
        t_fx aim_y;
        t_fx aim_z;
    } camera_view_t;

    // ------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_mode = MODE_UPDATE;
    logic signed [DATA_W-1:0] i_object_x = '0;
    logic signed [DATA_W-1:0] i_object_y = '0;
    logic signed [DATA_W-1:0] i_object_z = '0;
    logic signed [HEAD_W-1:0] i_heading_x = '0;
    logic signed [HEAD_W-1:0] i_heading_y = '0;
    logic signed [HEAD_W-1:0] i_heading_z = '0;
    logic [DT_W-1:0]          i_time_step = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_camera_x;
    logic signed [DATA_W-1:0] o_camera_y;
    logic signed [DATA_W-1:0] o_camera_z;
    logic signed [DATA_W-1:0] o_aim_x;
    logic signed [DATA_W-1:0] o_aim_y;
    logic signed [DATA_W-1:0] o_aim_z;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;

    damped_spring_follow_tracker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_object_x  (i_object_x),
        .i_object_y  (i_object_y),
        .i_object_z  (i_object_z),
        .i_heading_x (i_heading_x),
        .i_heading_y (i_heading_y),
        .i_heading_z (i_heading_z),
        .i_time_step (i_time_step),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_camera_x  (o_camera_x),
        .o_camera_y  (o_camera_y),
        .o_camera_z  (o_camera_z),
        .o_aim_x     (o_aim_x),
        .o_aim_y     (o_aim_y),
        .o_aim_z     (o_aim_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirrored registers and the camera's position and velocity
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] back_dist  = HDIST_RST;
    t_fx               lift_dist  = VDIST_RST;
    t_fx               look_dist  = LOOK_RST;
    logic [DIST_W-1:0] stiffness  = STIFF_RST;
    logic [DIST_W-1:0] damping    = DAMP_RST;
    t_fx               cam_pos[3] = '{default: '0};
    t_fx               cam_vel[3] = '{default: '0};

    object_beat_t object_beats[$];       // beats waiting to be offered
    camera_view_t camera_views_due[$];   // expected views, oldest first

    // Pacing knobs, changed by the sequence at rising edges only
    int gap_max     = 0;
    int stall_style = STALL_NONE;
    int hold_ticket = 0;

    int fault_count   = 0;
    int beats_taken   = 0;
    int snaps_taken   = 0;
    int views_checked = 0;
    int cycle_count   = 0;

    int trail[3] = '{default: 0};        // position of the followed object in tracked runs

    // ------------------------------------------------------------------
    // Fixed-point helpers: exact 64-bit math, then clamp to 32 bits
    // ------------------------------------------------------------------
    function automatic t_fx clamp32(input longint v);
        if (v > longint'(FX_MAX)) return FX_MAX;
        if (v < longint'(FX_MIN)) return FX_MIN;
        return t_fx'(v);
    endfunction

    // Q16.16 product, round half up
    function automatic t_fx scale_q(input t_fx a, input longint b);
        longint p;
        p = longint'(a) * b + (longint'(1) << (FRAC_BITS - 1));
        return clamp32(p >>> FRAC_BITS);
    endfunction

    // Product with the Q0.16 time step, round half up
    function automatic t_fx scale_dt(input t_fx a, input logic [DT_W-1:0] dt);
        longint p;
        p = longint'(a) * longint'(dt) + (longint'(1) << (TIME_BITS - 1));
        return clamp32(p >>> TIME_BITS);
    endfunction

    // Advance the camera by one beat and return the view the block should emit.
    function automatic camera_view_t advance_camera(input object_beat_t b);
        t_fx obj[3];
        t_fx hd[3];
        t_fx ideal[3];
        t_fx aim[3];
        t_fx diff;
        t_fx pull;
        t_fx drag;
        t_fx accel;
        camera_view_t v;
        obj[0] = b.obj_x;
        obj[1] = b.obj_y;
        obj[2] = b.obj_z;
        hd[0] = $signed(b.hd_x);
        hd[1] = $signed(b.hd_y);
        hd[2] = $signed(b.hd_z);
        for (int i = 0; i < 3; i++) begin
            ideal[i] = clamp32(longint'(obj[i]) - longint'(scale_q(hd[i], longint'(back_dist))));
            aim[i]   = clamp32(longint'(obj[i]) + longint'(scale_q(hd[i], longint'(look_dist))));
        end
        ideal[1] = clamp32(longint'(ideal[1]) + longint'(lift_dist));
        for (int i = 0; i < 3; i++) begin
            if (b.mode == MODE_SNAP) begin
                cam_pos[i] = ideal[i];
                cam_vel[i] = '0;
            end else begin
                // semi-implicit Euler: velocity first, then position with the new velocity
                diff  = clamp32(longint'(cam_pos[i]) - longint'(ideal[i]));
                pull  = scale_q(diff, longint'(stiffness));
                drag  = scale_q(cam_vel[i], longint'(damping));
                accel = clamp32(-longint'(pull) - longint'(drag));
                cam_vel[i] = clamp32(longint'(cam_vel[i]) + longint'(scale_dt(accel, b.dt)));
                cam_pos[i] = clamp32(longint'(cam_pos[i]) + longint'(scale_dt(cam_vel[i], b.dt)));
            end
        end
        v.cam_x = cam_pos[0];
        v.cam_y = cam_pos[1];
        v.cam_z = cam_pos[2];
        v.aim_x = aim[0];
        v.aim_y = aim[1];
        v.aim_z = aim[2];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run timed out after %0d cycles, %0d views still due",
                   cycle_count, camera_views_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer queued beats in bursts with random gaps. A stalled beat
    // holds its payload; valid is only ever assigned once per falling edge.
    // ------------------------------------------------------------------
    logic         in_taken = 1'b0;       // beat accepted at the last rising edge
    int           burst_left = 1;
    int           gap_left = 0;
    object_beat_t next_beat;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (object_beats.size() != 0) begin
                next_beat = object_beats.pop_front();
                i_mode      <= next_beat.mode;
                i_object_x  <= next_beat.obj_x;
                i_object_y  <= next_beat.obj_y;
                i_object_z  <= next_beat.obj_z;
                i_heading_x <= next_beat.hd_x;
                i_heading_y <= next_beat.hd_y;
                i_heading_z <= next_beat.hd_z;
                i_time_step <= next_beat.dt;
                i_in_valid  <= 1'b1;
                // end of a burst: pick the next burst length and the gap before it
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = int'($urandom_range(1, 12));
                    gap_left   = (gap_max == 0) ? 0 : int'($urandom_range(0, gap_max));
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on its own pattern; a new hold ticket forces a long
    // hold-off so the block fills and stalls its input.
    // ------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;
    int stall_tick = 0;

    always @(negedge i_clk) begin
        stall_tick++;
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_style)
                STALL_RANDOM: i_out_stall <= ($urandom_range(0, 99) < 35);
                STALL_COMB:   i_out_stall <= ((stall_tick % 11) < 4);
                default:      i_out_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input monitor: predict the view for every accepted beat
    // ------------------------------------------------------------------
    object_beat_t taken_beat;

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            taken_beat.mode  = i_mode;
            taken_beat.obj_x = i_object_x;
            taken_beat.obj_y = i_object_y;
            taken_beat.obj_z = i_object_z;
            taken_beat.hd_x  = i_heading_x;
            taken_beat.hd_y  = i_heading_y;
            taken_beat.hd_z  = i_heading_z;
            taken_beat.dt    = i_time_step;
            camera_views_due.push_back(advance_camera(taken_beat));
            beats_taken++;
            if (i_mode == MODE_SNAP) snaps_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compare each accepted view with the oldest expectation
    // ------------------------------------------------------------------
    camera_view_t due_view;

    task automatic check_field(input string name, input t_fx want, input t_fx got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (camera_views_due.size() == 0) begin
                $error("view beat with nothing expected: camera %0d %0d %0d",
                       o_camera_x, o_camera_y, o_camera_z);
                fault_count++;
            end else begin
                due_view = camera_views_due.pop_front();
                check_field("camera_x", due_view.cam_x, o_camera_x);
                check_field("camera_y", due_view.cam_y, o_camera_y);
                check_field("camera_z", due_view.cam_z, o_camera_z);
                check_field("aim_x", due_view.aim_x, o_aim_x);
                check_field("aim_y", due_view.aim_y, o_aim_y);
                check_field("aim_z", due_view.aim_z, o_aim_z);
                views_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------

    // Write one register while the block is idle and mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_HDIST: back_dist = data[DIST_W-1:0];
            CFG_VDIST: lift_dist = $signed(data);
            CFG_LOOK:  look_dist = $signed(data);
            CFG_STIFF: stiffness = data[DIST_W-1:0];
            CFG_DAMP:  damping   = data[DIST_W-1:0];
            default: ;  // unmapped index: the block drops the write
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_beat(input logic mode, input t_fx ox, input t_fx oy, input t_fx oz,
                              input int hx, input int hy, input int hz, input int dt);
        object_beat_t b;
        b.mode  = mode;
        b.obj_x = ox;
        b.obj_y = oy;
        b.obj_z = oz;
        b.hd_x  = HEAD_W'(hx);
        b.hd_y  = HEAD_W'(hy);
        b.hd_z  = HEAD_W'(hz);
        b.dt    = DT_W'(dt);
        object_beats.push_back(b);
    endtask

    // Mostly a smoothly moving object with occasional snaps; the rest is noise.
    function automatic object_beat_t pick_beat();
        object_beat_t b;
        int roll;
        int hd[3];
        roll = int'($urandom_range(0, 99));
        if (roll >= 82) begin
            b.mode  = 1'($urandom());
            b.obj_x = t_fx'($urandom());
            b.obj_y = t_fx'($urandom());
            b.obj_z = t_fx'($urandom());
            b.hd_x  = HEAD_W'($urandom());
            b.hd_y  = HEAD_W'($urandom());
            b.hd_z  = HEAD_W'($urandom());
            b.dt    = DT_W'($urandom());
            return b;
        end
        for (int i = 0; i < 3; i++) begin
            trail[i] += int'($urandom_range(0, 524288)) - 262144;
        end
        case ($urandom_range(0, 3))
            0: hd = '{65536, 0, 0};
            1: hd = '{0, 0, -65536};
            2: hd = '{46341, 0, -46341};
            default: begin
                for (int i = 0; i < 3; i++) hd[i] = int'($urandom_range(0, 131072)) - 65536;
            end
        endcase
        b.mode  = (roll < 8) ? MODE_SNAP : MODE_UPDATE;
        b.obj_x = t_fx'(trail[0]);
        b.obj_y = t_fx'(trail[1]);
        b.obj_z = t_fx'(trail[2]);
        b.hd_x  = HEAD_W'(hd[0]);
        b.hd_y  = HEAD_W'(hd[1]);
        b.hd_z  = HEAD_W'(hd[2]);
        // frame-like steps mostly, now and then a long one
        b.dt = ($urandom_range(0, 9) == 0) ? DT_W'($urandom()) : DT_W'($urandom_range(0, 4369));
        return b;
    endfunction

    // Change pacing at a rising edge so the falling-edge drivers see it cleanly.
    task automatic set_pace(input int gap, input int style, input bit long_hold);
        @(posedge i_clk);
        gap_max     = gap;
        stall_style = style;
        if (long_hold) hold_ticket++;
    endtask

    // Wait until every queued beat is taken and every view has come back.
    task automatic settle();
        while (object_beats.size() != 0 || i_in_valid || camera_views_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        @(posedge i_clk);
        for (int k = 0; k < count; k++) object_beats.push_back(pick_beat());
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats on the reset register values, no idling on either side.
        set_pace(0, STALL_NONE, 1'b0);
        queue_beat(MODE_SNAP,   '0, '0, '0, 0, 0, 65536, 0);
        queue_beat(MODE_UPDATE, '0, '0, '0, 0, 0, 65536, 1092);
        queue_beat(MODE_UPDATE, '0, '0, '0, 0, 0, 65536, 1092);
        queue_beat(MODE_UPDATE, 32'sd655360, 32'sd131072, -32'sd327680, 65536, 0, 0, 0);
        queue_beat(MODE_UPDATE, 32'sd655360, 32'sd131072, -32'sd327680, 65536, 0, 0, 65535);
        queue_beat(MODE_UPDATE, 32'sd655360, 32'sd131072, -32'sd327680, 65536, 0, 0, 546);
        // snap ignores the time step; ideal saturates at the top, aim stays just below it
        queue_beat(MODE_SNAP,   FX_MAX, FX_MAX, FX_MAX, -65536, -65536, -65536, 65535);
        queue_beat(MODE_UPDATE, FX_MAX, FX_MAX, FX_MAX, 65536, 65536, 65536, 65535);
        queue_beat(MODE_SNAP,   FX_MIN, FX_MIN, FX_MIN, 65536, 65536, 65536, 0);
        queue_beat(MODE_UPDATE, FX_MIN, FX_MIN, FX_MIN, -65536, -65536, -65536, 65535);
        // headings well off unit length, out to the raw field limits
        queue_beat(MODE_UPDATE, '0, '0, '0, 131071, -131072, 46341, 32768);
        queue_beat(MODE_UPDATE, '0, '0, '0, -131072, 131071, 0, 1);
        queue_beat(MODE_SNAP,   32'sd1, -32'sd1, 32'sd32767, 0, 0, 0, 0);
        queue_beat(MODE_UPDATE, FX_MAX, FX_MIN, '0, 131071, 131071, -131072, 65535);
        queue_beat(MODE_UPDATE, '0, '0, '0, 0, 0, 0, 65535);
        queue_beat(MODE_UPDATE, '0, '0, '0, 0, 0, 0, 65535);
        for (int k = 0; k < 5; k++) begin
            queue_beat(MODE_UPDATE, 32'sd327680, '0, '0, 46341, 0, 46341, 1092);
        end
        settle();

        // Game-like tuning: k = 16, damping = 2*sqrt(k); unmapped indexes must be dropped.
        write_reg(CFG_HDIST, 32'h000A_0000);
        write_reg(CFG_VDIST, 32'hFFFE_0000);
        write_reg(CFG_LOOK,  32'h0005_0000);
        write_reg(CFG_STIFF, 32'h0010_0000);
        write_reg(CFG_DAMP,  32'h0008_0000);
        write_reg(3'd5, ALL_ONES);
        write_reg(3'd6, ALL_ONES);
        write_reg(3'd7, ALL_ZERO);
        set_pace(40, STALL_RANDOM, 1'b0);
        random_phase(250);

        // Top extremes, bottom for the look distance; bit 31 of the unsigned registers must be masked off.
        write_reg(CFG_HDIST, ALL_ONES);
        write_reg(CFG_VDIST, 32'h7FFF_FFFF);
        write_reg(CFG_LOOK,  32'h8000_0000);
        write_reg(CFG_STIFF, ALL_ONES);
        write_reg(CFG_DAMP,  ALL_ONES);
        set_pace(15, STALL_COMB, 1'b1);
        random_phase(100);

        // All registers zero, back to back with no idling.
        write_reg(CFG_HDIST, ALL_ZERO);
        write_reg(CFG_VDIST, ALL_ZERO);
        write_reg(CFG_LOOK,  ALL_ZERO);
        write_reg(CFG_STIFF, ALL_ZERO);
        write_reg(CFG_DAMP,  ALL_ZERO);
        set_pace(0, STALL_NONE, 1'b0);
        random_phase(100);

        // Bottom extreme for the vertical distance, top for the look distance, soft spring, tiny distance.
        write_reg(CFG_HDIST, 32'h0000_0001);
        write_reg(CFG_VDIST, 32'h8000_0000);
        write_reg(CFG_LOOK,  32'h7FFF_FFFF);
        write_reg(CFG_STIFF, 32'h0001_0000);
        write_reg(CFG_DAMP,  32'h0002_0000);
        set_pace(60, STALL_RANDOM, 1'b1);
        random_phase(250);

        if (camera_views_due.size() != 0) begin
            $error("%0d expected views never arrived", camera_views_due.size());
            fault_count++;
        end
        $display("Run covered %0d object beats (%0d snaps) over five register settings,",
                 beats_taken, snaps_taken);
        $display("with %0d camera views compared field by field and %0d faults.",
                 views_checked, fault_count);
        if (fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/dsft_pkg.sv
design/dsft_ctrl.sv
design/dsft_dp.sv
design/damped_spring_follow_tracker_top.sv
tb/sv/damped_spring_follow_tracker_top_tb.sv
